[sv/whf_pkg.sv]
// ----------------------------------------------------------------------------
// Weighted Hermite function package
// Shared widths, fixed-point constants, register indexes and the constant
// normalization table 1/sqrt(2*pi*n!) in unsigned Q0.32.
// ----------------------------------------------------------------------------
package whf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int VALUE_W    = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int ORDER_W    = 4;
    localparam int MAX_ORDER  = 15;

    localparam int TAYLOR_TERMS = 16;
    localparam int SQUARINGS    = 6;

    localparam logic [63:0] QLIM           = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] QLIM_NEG       = 64'h8000_0000_0000_0001;
    localparam logic [63:0] ONE_Q62        = 64'h4000_0000_0000_0000;
    localparam logic [63:0] ONE_Q16        = 64'h0000_0000_0001_0000;
    localparam logic [63:0] INV_TWO_PI_Q64 = 64'd2935890503282001438;

    localparam logic signed [64:0] QLIM_P = {1'b0, QLIM};
    localparam logic signed [64:0] QLIM_N = -QLIM_P;

    localparam logic signed [63:0] OUT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] OUT_MIN = 64'shFFFF_FFFF_8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POLY_ORDER   = 8'd0,
        REG_CUTOFF_LEVEL = 8'd1,
        REG_COEF_BELOW   = 8'd2,
        REG_COEF_ABOVE   = 8'd3
    } t_reg_idx;

    typedef logic [MAX_ORDER:0][31:0] t_norm_tab;

    // Entry n is floor(sqrt(W_n)) with W_0 = 1/(2*pi) in Q0.64 and
    // W_n = floor(W_(n-1) / n).
    function automatic t_norm_tab f_norm_tab();
        t_norm_tab   tab;
        logic [63:0] w;
        logic [63:0] rest;
        logic [63:0] root;
        logic [63:0] bitv;
        w = INV_TWO_PI_Q64;
        for (int n = 0; n <= MAX_ORDER; n++) begin
            if (n > 0) begin
                w = w / 64'(n);
            end
            rest = w;
            root = '0;
            bitv = 64'h4000_0000_0000_0000;
            while (bitv > rest) begin
                bitv = bitv >> 2;
            end
            while (bitv != '0) begin
                if (rest >= root + bitv) begin
                    rest = rest - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            tab[n] = root[31:0];
        end
        return tab;
    endfunction

    localparam t_norm_tab NORM_TAB = f_norm_tab();

endpackage

[sv/whf_in_if.sv]
// ----------------------------------------------------------------------------
// Weighted Hermite function input channel
// Valid/ready channel that carries one sample item.
// ----------------------------------------------------------------------------
interface whf_in_if import whf_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_x;

    modport source (output valid, output sample_x, input ready);
    modport sink (input valid, input sample_x, output ready);

endinterface

[sv/whf_out_if.sv]
// ----------------------------------------------------------------------------
// Weighted Hermite function output channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface whf_out_if import whf_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value_out;
    logic                      saturated;

    modport source (output valid, output value_out, output saturated, input ready);
    modport sink (input valid, input value_out, input saturated, output ready);

endinterface

[sv/whf_cfg_if.sv]
// ----------------------------------------------------------------------------
// Weighted Hermite function configuration channel
// Valid/ready write channel that carries a register index and its data.
// ----------------------------------------------------------------------------
interface whf_cfg_if import whf_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_data;

    modport source (output valid, output reg_index, output reg_data, input ready);
    modport sink (input valid, input reg_index, input reg_data, output ready);

endinterface

[sv/weighted_hermite_function_core.sv]
// ----------------------------------------------------------------------------
// Weighted Hermite function core
// One item is processed at a time: a new sample is accepted only in the
// idle state. The processing time grows with the polynomial order m and is
// set by the shared 32x32 multiplier, which builds each 64x64 product from
// partial products, and by the Taylor series of the Gaussian with its 16
// divisions. A finished result waits in an output register while the next
// item is accepted. Synchronous reset clears the control state and loads the
// register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module weighted_hermite_function_core import whf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    whf_cfg_if.sink    i_cfg,
    whf_in_if.sink     i_in,
    whf_out_if.source  o_out
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_REC_PR = 10'b00_0000_0010,
        S_REC_SC = 10'b00_0000_0100,
        S_G_SQ   = 10'b00_0000_1000,
        S_G_TERM = 10'b00_0001_0000,
        S_G_DIV  = 10'b00_0010_0000,
        S_G_SQR  = 10'b00_0100_0000,
        S_CH_P1  = 10'b00_1000_0000,
        S_CH_P2  = 10'b01_0000_0000,
        S_CH_P3  = 10'b10_0000_0000
    } t_state;

    typedef enum logic [2:0] {
        SH_0  = 3'd0,
        SH_16 = 3'd1,
        SH_32 = 3'd2,
        SH_46 = 3'd3,
        SH_62 = 3'd4
    } t_shift;

    localparam logic [2:0] MUL_ACC_LAST = 3'd4;
    localparam logic [2:0] MUL_RES      = 3'd5;
    localparam logic [2:0] MUL_LAST     = 3'd6;
    localparam logic [2:0] DIV_LAST     = 3'd7;

    function automatic logic [63:0] f_mag(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    t_state                      r_state, n_state;
    logic [2:0]                  r_mc, n_mc;
    logic [4:0]                  r_cnt, n_cnt;
    logic                        r_ovalid, n_ovalid;
    logic [ORDER_W-1:0]          r_poly_order, n_poly_order;
    logic signed [SAMPLE_W-1:0]  r_cutoff, n_cutoff;
    logic signed [VALUE_W-1:0]   r_coef_below, n_coef_below;
    logic signed [VALUE_W-1:0]   r_coef_above, n_coef_above;

    logic [63:0]                 r_pp, n_pp;
    logic [127:0]                r_acc, n_acc;
    logic signed [63:0]          r_mres, n_mres;
    logic                        r_movf, n_movf;
    logic signed [SAMPLE_W-1:0]  r_x, n_x;
    logic [ORDER_W-1:0]          r_order, n_order;
    logic signed [63:0]          r_lowt, n_lowt;
    logic signed [63:0]          r_hight, n_hight;
    logic signed [63:0]          r_pr, n_pr;
    logic [63:0]                 r_s, n_s;
    logic [63:0]                 r_term, n_term;
    logic [63:0]                 r_sum, n_sum;
    logic [4:0]                  r_drem, n_drem;
    logic                        r_sat, n_sat;
    logic signed [VALUE_W-1:0]   r_value, n_value;
    logic                        r_osat, n_osat;

    logic                        mul_state;
    logic                        mul_done;
    logic [63:0]                 mul_a;
    logic [63:0]                 mul_b;
    t_shift                      mul_sh;
    logic                        mul_neg;
    logic [31:0]                 a_half;
    logic [31:0]                 b_half;
    logic [1:0]                  pp_idx;
    logic [127:0]                pp_sh;
    logic [127:0]                acc_sh;
    logic                        mul_over;
    logic [63:0]                 mres_mag;
    logic [63:0]                 mres;
    logic signed [63:0]          xq_r;
    logic signed [63:0]          xq_in;
    logic signed [63:0]          herm;
    logic signed [63:0]          k64;
    logic signed [64:0]          dif;
    logic signed [63:0]          sub_res;
    logic                        sub_sat;
    logic [4:0]                  div_rem;
    logic [63:0]                 div_q;
    logic [ORDER_W-1:0]          order_in;
    logic                        out_free;

    assign i_cfg.ready     = 1'b1;
    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.value_out = r_value;
    assign o_out.saturated = r_osat;

    assign xq_r  = {{44{r_x[SAMPLE_W-1]}}, r_x, 4'b0000};
    assign xq_in = {{44{i_in.sample_x[SAMPLE_W-1]}}, i_in.sample_x, 4'b0000};
    assign herm  = (r_order == '0) ? r_lowt : r_hight;
    assign k64   = (r_x <= r_cutoff) ? 64'(r_coef_below) : 64'(r_coef_above);
    assign order_in = (r_poly_order > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER)
                                                           : r_poly_order;
    assign out_free = !r_ovalid || o_out.ready;

    assign mul_state = (r_state == S_REC_PR) || (r_state == S_REC_SC) ||
                       (r_state == S_G_SQ) || (r_state == S_G_TERM) ||
                       (r_state == S_G_SQR) || (r_state == S_CH_P1) ||
                       (r_state == S_CH_P2) || (r_state == S_CH_P3);
    assign mul_done  = mul_state && (r_mc == MUL_LAST);

    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_sh  = SH_0;
        mul_neg = 1'b0;
        case (r_state)
            S_REC_PR: begin
                mul_a   = f_mag(xq_r);
                mul_b   = f_mag(r_hight);
                mul_sh  = SH_16;
                mul_neg = xq_r[63] ^ r_hight[63];
            end
            S_REC_SC: begin
                mul_a   = f_mag(r_lowt);
                mul_b   = {59'b0, r_cnt};
                mul_neg = r_lowt[63];
            end
            S_G_SQ: begin
                mul_a = f_mag(64'(r_x));
                mul_b = f_mag(64'(r_x));
            end
            S_G_TERM: begin
                mul_a  = r_term;
                mul_b  = r_s;
                mul_sh = SH_62;
            end
            S_G_SQR: begin
                mul_a  = r_sum;
                mul_b  = r_sum;
                mul_sh = SH_62;
            end
            S_CH_P1: begin
                mul_a   = f_mag(herm);
                mul_b   = r_sum;
                mul_sh  = SH_46;
                mul_neg = herm[63];
            end
            S_CH_P2: begin
                mul_a   = f_mag(r_term);
                mul_b   = {32'b0, NORM_TAB[r_order]};
                mul_sh  = SH_32;
                mul_neg = r_term[63];
            end
            S_CH_P3: begin
                mul_a   = f_mag(r_term);
                mul_b   = f_mag(k64);
                mul_sh  = SH_32;
                mul_neg = r_term[63] ^ k64[63];
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    assign a_half = r_mc[1] ? mul_a[63:32] : mul_a[31:0];
    assign b_half = r_mc[0] ? mul_b[63:32] : mul_b[31:0];
    assign pp_idx = 2'(r_mc[1:0] - 2'd1);

    always_comb begin
        case (pp_idx)
            2'd0:    pp_sh = {64'b0, r_pp};
            2'd3:    pp_sh = {r_pp, 64'b0};
            default: pp_sh = {32'b0, r_pp, 32'b0};
        endcase
    end

    always_comb begin
        case (mul_sh)
            SH_16:   acc_sh = r_acc >> 16;
            SH_32:   acc_sh = r_acc >> 32;
            SH_46:   acc_sh = r_acc >> 46;
            SH_62:   acc_sh = r_acc >> 62;
            default: acc_sh = r_acc;
        endcase
        mul_over = |acc_sh[127:63];
        mres_mag = mul_over ? QLIM : acc_sh[63:0];
        mres     = mul_neg ? 64'(-mres_mag) : mres_mag;
    end

    always_comb begin
        dif     = {r_pr[63], r_pr} - {r_mres[63], r_mres};
        sub_sat = 1'b0;
        if (dif > QLIM_P) begin
            sub_res = QLIM;
            sub_sat = 1'b1;
        end else if (dif < QLIM_N) begin
            sub_res = QLIM_NEG;
            sub_sat = 1'b1;
        end else begin
            sub_res = dif[63:0];
        end
    end

    always_comb begin
        div_rem = r_drem;
        div_q   = r_term;
        for (int i = 0; i < 8; i++) begin
            div_rem = {div_rem[3:0], div_q[63]};
            div_q   = {div_q[62:0], 1'b0};
            if (div_rem >= r_cnt) begin
                div_rem  = div_rem - r_cnt;
                div_q[0] = 1'b1;
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_mc         = r_mc;
        n_cnt        = r_cnt;
        n_ovalid     = r_ovalid;
        n_poly_order = r_poly_order;
        n_cutoff     = r_cutoff;
        n_coef_below = r_coef_below;
        n_coef_above = r_coef_above;
        n_pp         = 64'(a_half) * 64'(b_half);
        n_acc        = r_acc;
        n_mres       = r_mres;
        n_movf       = r_movf;
        n_x          = r_x;
        n_order      = r_order;
        n_lowt       = r_lowt;
        n_hight      = r_hight;
        n_pr         = r_pr;
        n_s          = r_s;
        n_term       = r_term;
        n_sum        = r_sum;
        n_drem       = r_drem;
        n_sat        = r_sat;
        n_value      = r_value;
        n_osat       = r_osat;

        if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                REG_POLY_ORDER:   n_poly_order = i_cfg.reg_data[ORDER_W-1:0];
                REG_CUTOFF_LEVEL: n_cutoff     = i_cfg.reg_data[SAMPLE_W-1:0];
                REG_COEF_BELOW:   n_coef_below = i_cfg.reg_data[VALUE_W-1:0];
                REG_COEF_ABOVE:   n_coef_above = i_cfg.reg_data[VALUE_W-1:0];
                default:          n_poly_order = r_poly_order;
            endcase
        end

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        if (mul_state) begin
            n_mc = mul_done ? 3'd0 : 3'(r_mc + 3'd1);
            if (r_mc == 3'd0) begin
                n_acc = '0;
            end else if (r_mc <= MUL_ACC_LAST) begin
                n_acc = r_acc + pp_sh;
            end
            if (r_mc == MUL_RES) begin
                n_mres = mres;
                n_movf = mul_over;
            end
        end

        case (r_state)
            S_IDLE: begin
                n_mc = '0;
                if (i_in.valid) begin
                    n_x     = i_in.sample_x;
                    n_order = order_in;
                    n_lowt  = ONE_Q16;
                    n_hight = xq_in;
                    n_cnt   = 5'd1;
                    n_sat   = 1'b0;
                    n_state = (order_in >= ORDER_W'(2)) ? S_REC_PR : S_G_SQ;
                end
            end
            S_REC_PR: begin
                if (mul_done) begin
                    n_pr    = r_mres;
                    n_sat   = r_sat | r_movf;
                    n_state = S_REC_SC;
                end
            end
            S_REC_SC: begin
                if (mul_done) begin
                    n_sat   = r_sat | r_movf | sub_sat;
                    n_lowt  = r_hight;
                    n_hight = sub_res;
                    n_cnt   = 5'(r_cnt + 5'd1);
                    n_state = (5'(r_cnt + 5'd1) == {1'b0, r_order}) ? S_G_SQ : S_REC_PR;
                end
            end
            S_G_SQ: begin
                if (mul_done) begin
                    n_s     = {r_mres[32:0], 31'b0};
                    n_term  = ONE_Q62;
                    n_sum   = ONE_Q62;
                    n_cnt   = 5'd1;
                    n_state = S_G_TERM;
                end
            end
            S_G_TERM: begin
                if (mul_done) begin
                    n_term  = r_mres;
                    n_drem  = '0;
                    n_state = S_G_DIV;
                end
            end
            S_G_DIV: begin
                n_mc   = 3'(r_mc + 3'd1);
                n_term = div_q;
                n_drem = div_rem;
                if (r_mc == DIV_LAST) begin
                    n_sum = r_cnt[0] ? (r_sum - div_q) : (r_sum + div_q);
                    if (r_cnt == 5'(TAYLOR_TERMS)) begin
                        n_cnt   = '0;
                        n_state = S_G_SQR;
                    end else begin
                        n_cnt   = 5'(r_cnt + 5'd1);
                        n_state = S_G_TERM;
                    end
                end
            end
            S_G_SQR: begin
                if (mul_done) begin
                    n_sum = r_mres;
                    n_cnt = 5'(r_cnt + 5'd1);
                    if (r_cnt == 5'(SQUARINGS - 1)) begin
                        n_state = S_CH_P1;
                    end
                end
            end
            S_CH_P1: begin
                if (mul_done) begin
                    n_term  = r_mres;
                    n_sat   = r_sat | r_movf;
                    n_state = S_CH_P2;
                end
            end
            S_CH_P2: begin
                if (mul_done) begin
                    n_term  = r_mres;
                    n_sat   = r_sat | r_movf;
                    n_state = S_CH_P3;
                end
            end
            S_CH_P3: begin
                if (mul_done) begin
                    if (out_free) begin
                        n_ovalid = 1'b1;
                        n_state  = S_IDLE;
                        if (r_mres > OUT_MAX) begin
                            n_value = OUT_MAX[VALUE_W-1:0];
                            n_osat  = 1'b1;
                        end else if (r_mres < OUT_MIN) begin
                            n_value = OUT_MIN[VALUE_W-1:0];
                            n_osat  = 1'b1;
                        end else begin
                            n_value = r_mres[VALUE_W-1:0];
                            n_osat  = r_sat | r_movf;
                        end
                    end else begin
                        n_mc = r_mc;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mc         <= '0;
            r_cnt        <= '0;
            r_ovalid     <= 1'b0;
            r_poly_order <= '0;
            r_cutoff     <= 16'sd8192;
            r_coef_below <= '0;
            r_coef_above <= '0;
            r_lowt       <= '0;
            r_hight      <= '0;
            r_order      <= '0;
        end else begin
            r_state      <= n_state;
            r_mc         <= n_mc;
            r_cnt        <= n_cnt;
            r_ovalid     <= n_ovalid;
            r_poly_order <= n_poly_order;
            r_cutoff     <= n_cutoff;
            r_coef_below <= n_coef_below;
            r_coef_above <= n_coef_above;
            r_lowt       <= n_lowt;
            r_hight      <= n_hight;
            r_order      <= n_order;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pp    <= n_pp;
        r_acc   <= n_acc;
        r_mres  <= n_mres;
        r_movf  <= n_movf;
        r_x     <= n_x;
        r_pr    <= n_pr;
        r_s     <= n_s;
        r_term  <= n_term;
        r_sum   <= n_sum;
        r_drem  <= n_drem;
        r_sat   <= n_sat;
        r_value <= n_value;
        r_osat  <= n_osat;
    end

`ifndef SYNTHESIS
    a_mul_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_G_DIV) |-> (r_mc <= MUL_LAST))
        else $error("multiplier phase out of range");

    a_out_from_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_CH_P3))
        else $error("result loaded outside the final product step");

    a_div_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_G_DIV) |-> (r_cnt != '0 && r_cnt <= 5'(TAYLOR_TERMS)))
        else $error("series divisor out of range");

    a_rec_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REC_PR) |-> (r_cnt < {1'b0, r_order}))
        else $error("recurrence step beyond the polynomial order");
`endif

endmodule
